### hdl/elx_pkg.sv
// ----------------------------------------------------------------------------
// elx_pkg: shared types and constants of the expression lexer
// Token kinds, lexer modes, character codes and the result record.
// ----------------------------------------------------------------------------
package elx_pkg;

  localparam int POS_BITS    = 16;
  localparam int FIELD_BITS  = 16;
  localparam int VALUE_BITS  = 63;
  localparam int MAX_RESULTS = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int LVL_BITS    = QPTR_BITS + 1;

  localparam logic [VALUE_BITS-1:0] NUM_MAX = '1;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    KIND_LPAREN     = 4'd0,
    KIND_RPAREN     = 4'd1,
    KIND_CARET      = 4'd2,
    KIND_PERCENT    = 4'd3,
    KIND_SLASH      = 4'd4,
    KIND_STAR       = 4'd5,
    KIND_MINUS      = 4'd6,
    KIND_PLUS       = 4'd7,
    KIND_NUMBER     = 4'd8,
    KIND_VARIABLE   = 4'd9,
    KIND_BAD_SYMBOL = 4'd10,
    KIND_OVERFLOW   = 4'd11,
    KIND_END        = 4'd12
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_VAR  = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_BITS-1:0]  value;
    logic [FIELD_BITS-1:0]  position;
    logic [FIELD_BITS-1:0]  length;
    logic                   last;
  } res_t;

  // Results of one character, in emission order, and how many are valid.
  typedef struct packed {
    logic [1:0]             count;
    res_t [MAX_RESULTS-1:0] slot;
  } step_out_t;

  typedef struct packed {
    logic                room;
    logic [LVL_BITS-1:0] level;
  } q_stat_t;

  // Indices wrap at POS_BITS; the output fields keep their low bits.
  function automatic logic [FIELD_BITS-1:0] pos_to_field(pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[FIELD_BITS-1:0];
  endfunction

  function automatic res_t mk_res(kind_t k, logic [VALUE_BITS-1:0] v, pos_t p, pos_t l);
    res_t r;
    r.kind     = k;
    r.value    = v;
    r.position = pos_to_field(p);
    r.length   = pos_to_field(l);
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

### hdl/elx_step.sv
// ----------------------------------------------------------------------------
// elx_step: lexer state and per-character token logic
// Holds the lexer mode, number accumulator and positions, and forms the
// tokens that one character produces.
// ----------------------------------------------------------------------------
module elx_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         char_code,
  input  logic               end_of_text,
  output elx_pkg::step_out_t step_out
);
  import elx_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;
  pos_t                  start_r, start_nxt;
  pos_t                  idx_r, idx_nxt;

  logic                  is_alpha, is_digit, is_space, op_hit;
  kind_t                 op_kind;
  logic [VALUE_BITS+3:0] prod;
  pos_t                  end_pos;
  logic [1:0]            cnt;
  res_t [MAX_RESULTS-1:0] slot;

  always_comb begin
    is_alpha = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    is_digit = (char_code inside {[8'h30:8'h39]});
    is_space = (char_code == 8'h20) || (char_code inside {[8'd9:8'd13]});
  end

  always_comb begin
    op_hit  = 1'b1;
    op_kind = KIND_LPAREN;
    case (char_code)
      CH_LPAREN:  op_kind = KIND_LPAREN;
      CH_RPAREN:  op_kind = KIND_RPAREN;
      CH_CARET:   op_kind = KIND_CARET;
      CH_PERCENT: op_kind = KIND_PERCENT;
      CH_SLASH:   op_kind = KIND_SLASH;
      CH_STAR:    op_kind = KIND_STAR;
      CH_MINUS:   op_kind = KIND_MINUS;
      CH_PLUS:    op_kind = KIND_PLUS;
      default:    op_hit  = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    start_nxt = start_r;
    idx_nxt   = idx_r;
    cnt       = '0;
    slot      = '0;
    end_pos   = idx_r + pos_t'(1);
    // acc * 10 + digit, wide enough to see a value past the 63-bit limit.
    prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (VALUE_BITS+4)'(char_code[3:0]);

    // Close or extend a pending run.
    case (mode_r)
      MODE_NUM: begin
        if (is_alpha) begin
          slot[cnt] = mk_res(KIND_BAD_SYMBOL, '0, idx_r, pos_t'(1));
          cnt       = cnt + 2'd1;
          mode_nxt  = MODE_ERR;
        end else if (is_digit) begin
          if (!ovf_r) begin
            if (prod > {4'b0, NUM_MAX}) begin
              ovf_nxt = 1'b1;
              acc_nxt = NUM_MAX;
            end else begin
              acc_nxt = prod[VALUE_BITS-1:0];
            end
          end
        end else begin
          if (ovf_r) begin
            slot[cnt] = mk_res(KIND_OVERFLOW, '0, idx_r, pos_t'(1));
            mode_nxt  = MODE_ERR;
          end else begin
            slot[cnt] = mk_res(KIND_NUMBER, acc_r, start_r, idx_r - start_r);
            mode_nxt  = MODE_IDLE;
          end
          cnt = cnt + 2'd1;
        end
      end
      MODE_VAR: begin
        if (!is_alpha && !is_digit) begin
          slot[cnt] = mk_res(KIND_VARIABLE, '0, start_r, idx_r - start_r);
          cnt       = cnt + 2'd1;
          mode_nxt  = MODE_IDLE;
        end
      end
      default: ;
    endcase

    // Outside error mode, a non-space character that no run took starts a token of its own.
    if (mode_nxt == MODE_IDLE && !is_space) begin
      if (op_hit) begin
        slot[cnt] = mk_res(op_kind, '0, idx_r, pos_t'(1));
        cnt       = cnt + 2'd1;
      end else if (is_alpha) begin
        mode_nxt  = MODE_VAR;
        start_nxt = idx_r;
      end else if (is_digit) begin
        mode_nxt  = MODE_NUM;
        start_nxt = idx_r;
        acc_nxt   = VALUE_BITS'(char_code[3:0]);
        ovf_nxt   = 1'b0;
      end else begin
        slot[cnt] = mk_res(KIND_BAD_SYMBOL, '0, idx_r, pos_t'(1));
        cnt       = cnt + 2'd1;
        mode_nxt  = MODE_ERR;
      end
    end

    if (end_of_text) begin
      if (mode_nxt == MODE_NUM) begin
        if (ovf_nxt) begin
          slot[cnt] = mk_res(KIND_OVERFLOW, '0, end_pos, pos_t'(1));
        end else begin
          slot[cnt] = mk_res(KIND_NUMBER, acc_nxt, start_nxt, end_pos - start_nxt);
        end
        cnt = cnt + 2'd1;
      end else if (mode_nxt == MODE_VAR) begin
        slot[cnt] = mk_res(KIND_VARIABLE, '0, start_nxt, end_pos - start_nxt);
        cnt       = cnt + 2'd1;
      end
      slot[cnt] = mk_res(KIND_END, '0, end_pos, pos_t'(1));
      cnt       = cnt + 2'd1;
      mode_nxt  = MODE_IDLE;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      start_nxt = '0;
      idx_nxt   = '0;
    end else begin
      idx_nxt = end_pos;
    end

    if (cnt != 2'd0) begin
      slot[cnt - 2'd1].last = 1'b1;
    end
    if (!fire) begin
      cnt = '0;
    end
    step_out.count = cnt;
    step_out.slot  = slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      start_r <= '0;
      idx_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      start_r <= start_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### hdl/elx_outq.sv
// ----------------------------------------------------------------------------
// elx_outq: token queue in front of the result channel
// Takes up to three tokens per cycle; presents one per cycle unless out_stall.
// ----------------------------------------------------------------------------
module elx_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  elx_pkg::step_out_t wr,
  input  logic               out_stall,
  output logic               out_valid,
  output elx_pkg::res_t      out_res,
  output elx_pkg::q_stat_t   stat
);
  import elx_pkg::*;

  res_t                 q_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_BITS-1:0]  level_r, level_nxt;
  logic [LVL_BITS-1:0]  level_after_pop;
  logic                 pop;

  assign out_valid = (level_r != '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    level_after_pop = level_r - LVL_BITS'(pop);
    // Room for the worst case of one character before it is taken.
    stat.room  = (level_after_pop <= LVL_BITS'(QDEPTH - MAX_RESULTS));
    stat.level = level_r;
    level_nxt  = level_after_pop + LVL_BITS'(wr.count);
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(wr.count);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < wr.count) begin
        q_r[wr_ptr_r + QPTR_BITS'(i)] <= wr.slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

### hdl/expression_char_lexer_core.sv
// ----------------------------------------------------------------------------
// expression_char_lexer_core: streaming lexer for arithmetic expressions
// Turns a character stream into operator, number and variable tokens.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | char_code, end_of_text
//  out_    | output    | out_valid / out_stall | kind, number_value, position,
//          |           |                       | token_length, run_last
//
// One character is taken per cycle while in_stall is low; it is registered,
// classified and its tokens (zero to three) are written into a four-entry
// queue. Tokens leave at one per cycle while out_stall is low, each in its
// own output transfer. The queue needs room for three tokens.
// Reset is synchronous and clears the lexer to idle at position zero.
// in_stall rises only while a registered character waits for queue room.
module expression_char_lexer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [3:0]                       out_kind,
  output logic [elx_pkg::VALUE_BITS-1:0]   out_number_value,
  output logic [elx_pkg::FIELD_BITS-1:0]   out_position,
  output logic [elx_pkg::FIELD_BITS-1:0]   out_token_length,
  output logic                             out_run_last
);
  import elx_pkg::*;

  logic       in_vld_r;
  logic [7:0] char_r;
  logic       eot_r;
  logic       fire;
  logic       in_take;
  step_out_t  step_out;
  q_stat_t    q_stat;
  res_t       out_res;

  assign fire     = in_vld_r && q_stat.room;
  assign in_stall = in_vld_r && !q_stat.room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_char_code;
      eot_r  <= in_end_of_text;
    end
  end

  elx_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .char_code   (char_r),
    .end_of_text (eot_r),
    .step_out    (step_out)
  );

  elx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (step_out),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .stat      (q_stat)
  );

  assign out_kind         = 4'(out_res.kind);
  assign out_number_value = out_res.value;
  assign out_position     = out_res.position;
  assign out_token_length = out_res.length;
  assign out_run_last     = out_res.last;

`ifndef SYNTHESIS
  // The last character of a text always yields at least its end token.
  a_eot_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && eot_r) |-> (step_out.count != 2'd0))
    else $error("end of text produced no token");

  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= LVL_BITS'(QDEPTH))
    else $error("token queue overfilled");

  // An end token closes the run of its character.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == 4'(KIND_END))) |-> out_run_last)
    else $error("end token not marked last");
`endif

endmodule
